FILE: src/ptb_pkg.sv
// Shared constants, payload types and control/status types for the periodic timer bank.
package ptb_pkg;

	localparam int TIMER_COUNT = 16;
	localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int ID_W        = 8;
	localparam int PERIOD_W    = 24;
	localparam int TIME_W      = 25;
	localparam int TICK_W      = 10;
	localparam int CNT_W       = (TIMER_COUNT > PERIOD_W) ? $clog2(TIMER_COUNT) : $clog2(PERIOD_W);

	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);
	localparam logic [CNT_W-1:0]  SCAN_LAST  = CNT_W'(TIMER_COUNT - 1);
	localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(PERIOD_W - 1);

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_REGISTER   = 3'd1,
		CMD_START      = 3'd2,
		CMD_STOP       = 3'd3,
		CMD_DELETE     = 3'd4,
		CMD_START_ALL  = 3'd5,
		CMD_STOP_ALL   = 3'd6,
		CMD_DELETE_ALL = 3'd7
	} ptb_cmd_t;

	typedef enum logic [0:0] {
		KIND_ACK    = 1'b0,
		KIND_EXPIRY = 1'b1
	} ptb_kind_t;

	typedef enum logic [0:0] {
		STAT_OK   = 1'b0,
		STAT_FAIL = 1'b1
	} ptb_stat_t;

	typedef struct packed {
		ptb_cmd_t              command;
		logic [ID_W-1:0]       timer_id;
		logic [PERIOD_W-1:0]   period_ms;
	} ptb_in_t;

	typedef struct packed {
		ptb_kind_t             event_kind;
		logic [ID_W-1:0]       expired_id;
		ptb_stat_t             status;
		logic                  last;
	} ptb_out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                  load;
		logic                  div_step;
		logic                  scan;
		logic                  flush;
		logic                  ack;
		logic [IDX_W-1:0]      idx;
	} ptb_ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		ptb_cmd_t              new_cmd;
		logic                  new_ok;
		ptb_cmd_t              cmd;
	} ptb_sts_t;

endpackage

FILE: src/ptb_ctrl.sv
// Sequencing state machine for the periodic timer bank.
module ptb_ctrl import ptb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ptb_sts_t sts,
	output logic     busy,
	output ptb_ctl_t ctl
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_FLUSH = 5'b01000,
		ST_ACK   = 5'b10000
	} ptb_state_t;

	ptb_state_t        state_q;
	ptb_state_t        state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic              accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (start) begin
					case (sts.new_cmd)
						CMD_TICK:     state_d = ST_SCAN;
						CMD_REGISTER: state_d = sts.new_ok ? ST_DIV : ST_ACK;
						default: begin
							if (sts.new_cmd inside {CMD_START_ALL, CMD_STOP_ALL, CMD_DELETE_ALL})
								state_d = ST_SCAN;
							else
								state_d = ST_ACK;
						end
					endcase
				end
			end
			ST_DIV: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == DIV_LAST)
					state_d = ST_ACK;
			end
			ST_SCAN: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == SCAN_LAST)
					state_d = (sts.cmd == CMD_TICK) ? ST_FLUSH : ST_ACK;
			end
			ST_FLUSH: state_d = ST_IDLE;
			ST_ACK:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		ctl.load     = accept;
		ctl.div_step = (state_q == ST_DIV);
		ctl.scan     = (state_q == ST_SCAN);
		ctl.flush    = (state_q == ST_FLUSH);
		ctl.ack      = (state_q == ST_ACK);
		ctl.idx      = cnt_q[IDX_W-1:0];
	end

`ifndef SYNTH
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ($past(state_q) == ST_ACK || $past(state_q) == ST_FLUSH))
		else $error("busy dropped outside ack or flush");

	a_div_to_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == DIV_LAST) |=> (state_q == ST_ACK))
		else $error("remainder pass did not end in ack");

	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.new_cmd == CMD_TICK) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("tick did not start a scan at entry zero");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cnt_q == SCAN_LAST) |=> (state_q == ST_FLUSH || state_q == ST_ACK))
		else $error("scan overran the bank");
`endif

endmodule

FILE: src/ptb_dp.sv
// Timer storage, remainder unit, countdown logic and result register.
module ptb_dp import ptb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ptb_in_t           item,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata,
	input  ptb_ctl_t          ctl,
	output ptb_sts_t          sts,
	output logic              strobe,
	output ptb_out_t          result
);

	logic [TICK_W-1:0]   tick_q;
	ptb_cmd_t            cmd_q;
	logic [ID_W-1:0]     id_q;
	logic                ok_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] shift_q;
	logic [TICK_W-1:0]   rem_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pend_id_q;
	logic [TIME_W-1:0]   rtime_q  [TIMER_COUNT];
	logic [TIME_W-1:0]   reload_q [TIMER_COUNT];
	logic                reg_q    [TIMER_COUNT];
	logic                strobe_q;
	ptb_out_t            result_q;

	logic                new_ok;
	logic [TICK_W-1:0]   t;
	logic [TIME_W-1:0]   t_ext;
	logic [TIME_W-1:0]   r;
	logic                active;
	logic [TIME_W-1:0]   dec;
	logic                exp_hit;
	logic [TICK_W:0]     cand;
	logic [TICK_W-1:0]   rem_d;
	logic [TIME_W-1:0]   rounded;
	logic [IDX_W-1:0]    aid;
	logic                out_v;
	ptb_out_t            out_d;

	assign new_ok = ({1'b0, item.timer_id} < (ID_W+1)'(TIMER_COUNT));

	assign sts.new_cmd = item.command;
	assign sts.new_ok  = new_ok;
	assign sts.cmd     = cmd_q;

	// zero tick length acts as one
	assign t     = (tick_q == '0) ? TICK_W'(1) : tick_q;
	assign t_ext = TIME_W'(t);

	// countdown of the scanned entry
	assign r       = rtime_q[ctl.idx];
	assign active  = (r != '0) && reg_q[ctl.idx];
	assign dec     = (r > t_ext) ? (r - t_ext) : '0;
	assign exp_hit = active && (dec < t_ext);

	// one remainder bit per step, most significant period bit first
	assign cand  = {rem_q, shift_q[PERIOD_W-1]};
	assign rem_d = (cand >= {1'b0, t}) ? TICK_W'(cand - {1'b0, t}) : cand[TICK_W-1:0];

	assign rounded = TIME_W'(period_q) + ((rem_q != '0) ? TIME_W'(t - rem_q) : '0);
	assign aid     = id_q[IDX_W-1:0];

	always_comb begin
		out_v = 1'b0;
		out_d = '{event_kind: KIND_EXPIRY, expired_id: ID_W'(pend_id_q),
			status: STAT_OK, last: 1'b0};
		if (ctl.scan && cmd_q == CMD_TICK && exp_hit && pend_q) begin
			out_v = 1'b1;
		end else if (ctl.flush && pend_q) begin
			out_v      = 1'b1;
			out_d.last = 1'b1;
		end else if (ctl.ack) begin
			out_v = 1'b1;
			out_d = '{event_kind: KIND_ACK, expired_id: id_q,
				status: (ok_q ? STAT_OK : STAT_FAIL), last: 1'b1};
		end
	end

	// capture the transaction, run the remainder unit and register each result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= item.command;
			id_q     <= item.timer_id;
			ok_q     <= new_ok || (item.command inside {CMD_START_ALL, CMD_STOP_ALL,
				CMD_DELETE_ALL});
			period_q <= item.period_ms;
			shift_q  <= item.period_ms;
			rem_q    <= '0;
		end else if (ctl.div_step) begin
			rem_q   <= rem_d;
			shift_q <= {shift_q[PERIOD_W-2:0], 1'b0};
		end
		if (out_v)
			result_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= TICK_RESET;
			pend_q    <= 1'b0;
			pend_id_q <= '0;
			strobe_q  <= 1'b0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				rtime_q[i]  <= '0;
				reload_q[i] <= '0;
				reg_q[i]    <= 1'b0;
			end
		end else begin
			strobe_q <= out_v;
			if (cfg_we)
				tick_q <= cfg_wdata;
			if (ctl.load)
				pend_q <= 1'b0;
			if (ctl.scan) begin
				case (cmd_q)
					CMD_TICK: begin
						if (active)
							rtime_q[ctl.idx] <= exp_hit ? reload_q[ctl.idx] : dec;
						if (exp_hit) begin
							pend_q    <= 1'b1;
							pend_id_q <= ctl.idx;
						end
					end
					CMD_START_ALL: rtime_q[ctl.idx] <= reload_q[ctl.idx];
					CMD_STOP_ALL:  rtime_q[ctl.idx] <= '0;
					CMD_DELETE_ALL: begin
						rtime_q[ctl.idx]  <= '0;
						reload_q[ctl.idx] <= '0;
						reg_q[ctl.idx]    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (ctl.flush)
				pend_q <= 1'b0;
			if (ctl.ack && ok_q) begin
				case (cmd_q)
					CMD_REGISTER: begin
						reload_q[aid] <= rounded;
						rtime_q[aid]  <= '0;
						reg_q[aid]    <= 1'b1;
					end
					CMD_START: rtime_q[aid] <= reload_q[aid];
					CMD_STOP:  rtime_q[aid] <= '0;
					CMD_DELETE: begin
						rtime_q[aid]  <= '0;
						reload_q[aid] <= '0;
						reg_q[aid]    <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

FILE: src/periodic_timer_bank_unit.sv
// Top level of the periodic timer bank: controller plus datapath.
//
//   channel   handshake                 payload
//   -------   -----------------------   -----------------------------------------
//   command   start in, busy out        item  (command, timer_id, period_ms)
//   result    strobe out, no backpress  result (event_kind, expired_id, status, last)
//   config    cfg_we in                 cfg_wdata (tick_ms)
//
// A transaction is taken at an edge with start high and busy low. After that
// the block stays busy while it steps through: the ack state for start, stop,
// delete and rejected register; the one bit per cycle remainder unit, which
// rounds the period up to a multiple of the tick length, then the ack for register;
// the scan that visits one timer entry per cycle, then a flush for tick or an ack
// for the bank-wide commands.
// Each result shows on result for one cycle with strobe high, in the cycle after
// the step that makes it; a tick holds each expiry back until the next is found
// so the final one can carry last. The receiver cannot stall, so nothing waits.
// Reset clears all timers, registrations and periods at once and sets the
// tick length to 10 ms; the block takes a transaction in the first cycle.
module periodic_timer_bank_unit import ptb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ptb_in_t           item,
	output logic              strobe,
	output ptb_out_t          result,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata
);

	ptb_ctl_t ctl;
	ptb_sts_t sts;

	// sequence the transaction
	ptb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	// hold the timers and produce results
	ptb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.strobe    (strobe),
		.result    (result)
	);

endmodule
